/* sv/tce_pkg.sv */
// tce_pkg: shared types, codes and reset values for the tcp connection engine
// used by tce_ctrl, tce_dp, tcp_connection_engine and tce_check
package tce_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int CFG_AW        = 4;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] MODE_CONNECT = 3'd0;
  localparam logic [2:0] MODE_SEGMENT = 3'd1;
  localparam logic [2:0] MODE_SEND    = 3'd2;
  localparam logic [2:0] MODE_TICK    = 3'd3;
  localparam logic [2:0] MODE_QUERY   = 3'd4;

  localparam logic [1:0] REG_FIRST_PORT = 2'd0;
  localparam logic [1:0] REG_RETRY_INT  = 2'd1;
  localparam logic [1:0] REG_RETRY_LIM  = 2'd2;
  localparam logic [1:0] REG_ISN_BASE   = 2'd3;

  localparam logic [15:0] FIRST_PORT_RST = 16'd49152;
  localparam logic [7:0]  RETRY_INT_RST  = 8'd50;
  localparam logic [7:0]  RETRY_LIM_RST  = 8'd15;
  localparam logic [31:0] ISN_BASE_RST   = 32'h1122_3344;

  localparam logic [7:0] FLG_FIN    = 8'h01;
  localparam logic [7:0] FLG_SYN    = 8'h02;
  localparam logic [7:0] FLG_RST    = 8'h04;
  localparam logic [7:0] FLG_ACK    = 8'h10;
  localparam logic [7:0] FLG_FINACK = 8'h11;
  localparam logic [7:0] FLG_PSHACK = 8'h18;

  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_NOFREE  = 2'd1;
  localparam logic [1:0] STS_IGNORED = 2'd2;

  typedef enum logic [1:0] {
    CS_CLOSED = 2'd0,
    CS_SYN    = 2'd1,
    CS_EST    = 2'd2
  } conn_st_t;

  typedef struct packed {
    logic [15:0] lport;
    logic [15:0] rport;
    logic [31:0] rip;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  retry_cnt;
    logic [7:0]  wait_cnt;
  } slot_rec_t;

  typedef struct packed {
    logic        has_segment;
    logic [3:0]  slot;
    logic [1:0]  slot_state;
    logic [1:0]  status;
    logic [15:0] tx_sport;
    logic [15:0] tx_dport;
    logic [31:0] tx_dip;
    logic [31:0] seq_out;
    logic [31:0] ack_out;
    logic [7:0]  flags_out;
  } res_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic apply;
    logic plain;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       cur_closed;
    logic       cur_syn;
    logic       match;
    logic       sock_ok;
  } dp_stat_t;

endpackage

/* sv/tce_ctrl.sv */
// tce_ctrl: sequencer that walks the slot table one slot at a time
// depends on tce_pkg; drives tce_dp through ctrl_cmd_t
module tce_ctrl import tce_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  dp_stat_t        stat,
  output ctrl_cmd_t       cmd,
  output logic [SW-1:0]   idx
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_FLUSH
  } state_t;

  state_t        state_r, state_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic          at_last;

  assign at_last = (idx_r == SW'(NUM_SLOTS - 1));
  assign busy    = (state_r != S_IDLE);
  assign idx     = idx_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        case (stat.mode)
          MODE_CONNECT: begin
            if (stat.cur_closed) begin
              cmd.apply = 1'b1;
              state_nxt = S_FLUSH;
            end else if (at_last) begin
              cmd.plain = 1'b1;
              state_nxt = S_FLUSH;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          MODE_SEGMENT: begin
            if (!stat.cur_closed) begin
              cmd.rd    = 1'b1;
              state_nxt = S_EVAL;
            end else if (at_last) begin
              cmd.plain = 1'b1;
              state_nxt = S_FLUSH;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          MODE_TICK: begin
            if (stat.cur_syn) begin
              cmd.rd    = 1'b1;
              state_nxt = S_EVAL;
            end else if (at_last) begin
              state_nxt = S_FLUSH;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          MODE_SEND: begin
            if (stat.sock_ok) begin
              cmd.rd    = 1'b1;
              state_nxt = S_EVAL;
            end else begin
              cmd.plain = 1'b1;
              state_nxt = S_FLUSH;
            end
          end
          default: begin
            cmd.plain = 1'b1;
            state_nxt = S_FLUSH;
          end
        endcase
      end
      S_EVAL: begin
        case (stat.mode)
          MODE_SEGMENT: begin
            if (stat.match) begin
              cmd.apply = 1'b1;
              state_nxt = S_FLUSH;
            end else if (at_last) begin
              cmd.plain = 1'b1;
              state_nxt = S_FLUSH;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_SCAN;
            end
          end
          MODE_TICK: begin
            cmd.apply = 1'b1;
            if (at_last) begin
              state_nxt = S_FLUSH;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            cmd.apply = 1'b1;
            state_nxt = S_FLUSH;
          end
        endcase
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

/* sv/tce_dp.sv */
// tce_dp: config registers, slot table memory, connection states and result staging
// depends on tce_pkg; controlled by tce_ctrl
module tce_dp import tce_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic [2:0]        in_mode,
  input  logic [3:0]        in_sock_index,
  input  logic [31:0]       in_peer_ip,
  input  logic [15:0]       in_peer_port,
  input  logic [15:0]       in_seg_src_port,
  input  logic [15:0]       in_seg_dst_port,
  input  logic [31:0]       in_seg_seq,
  input  logic [31:0]       in_seg_ack,
  input  logic [7:0]        in_seg_flags,
  input  logic [15:0]       in_data_len,
  input  ctrl_cmd_t         cmd,
  input  logic [SW-1:0]     idx,
  output dp_stat_t          stat,
  output logic              out_valid,
  output res_t              out_res,
  output logic              out_last
);

  logic [15:0] first_port_r;
  logic [7:0]  retry_int_r;
  logic [7:0]  retry_lim_r;
  logic [31:0] isn_base_r;
  logic [15:0] next_port_r;

  logic [2:0]  mode_r;
  logic [3:0]  sock_r;
  logic [31:0] pip_r;
  logic [15:0] pport_r;
  logic [15:0] sport_r;
  logic [15:0] dport_r;
  logic [31:0] sseq_r;
  logic [31:0] sack_r;
  logic [7:0]  flags_r;
  logic [15:0] dlen_r;

  conn_st_t  cs_r [NUM_SLOTS];
  slot_rec_t mem [NUM_SLOTS];
  slot_rec_t rdata_r;

  res_t             pend_r;
  logic             pend_v_r;
  logic [CNT_W-1:0] cnt_r;
  res_t             out_res_r;
  logic             out_valid_r;
  logic             out_last_r;

  logic          cfg_wr;
  logic          sock_ok;
  logic [SW-1:0] sock_ix;
  logic [SW-1:0] addr;
  conn_st_t      cs_cur;
  logic [3:0]    slot4;
  logic          mem_we;
  slot_rec_t     wrec;
  logic          cs_we;
  conn_st_t      cs_new;
  logic          prod;
  res_t          r;
  logic          np_inc;

  function automatic res_t mk_plain(logic [3:0] s, logic [1:0] st, logic [1:0] sts);
    res_t x;
    x            = '0;
    x.slot       = s;
    x.slot_state = st;
    x.status     = sts;
    return x;
  endfunction

  function automatic res_t mk_seg(logic [3:0] s, conn_st_t st, slot_rec_t rec,
                                  logic [31:0] sq, logic [31:0] ak, logic [7:0] fl);
    res_t x;
    x             = '0;
    x.has_segment = 1'b1;
    x.slot        = s;
    x.slot_state  = st;
    x.status      = STS_DONE;
    x.tx_sport    = rec.lport;
    x.tx_dport    = rec.rport;
    x.tx_dip      = rec.rip;
    x.seq_out     = sq;
    x.ack_out     = ak;
    x.flags_out   = fl;
    return x;
  endfunction

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign sock_ok = (32'(sock_r) < 32'(NUM_SLOTS));
  assign sock_ix = SW'(sock_r);
  assign addr    = (mode_r == MODE_SEND) ? sock_ix : idx;
  assign cs_cur  = cs_r[addr];
  assign slot4   = 4'(addr);

  always_comb begin
    unique case (paddr[3:2])
      REG_FIRST_PORT: prdata = {16'd0, first_port_r};
      REG_RETRY_INT:  prdata = {24'd0, retry_int_r};
      REG_RETRY_LIM:  prdata = {24'd0, retry_lim_r};
      REG_ISN_BASE:   prdata = isn_base_r;
      default:        prdata = '0;
    endcase
  end

  assign stat.mode       = mode_r;
  assign stat.cur_closed = (cs_cur == CS_CLOSED);
  assign stat.cur_syn    = (cs_cur == CS_SYN);
  assign stat.match      = (cs_cur != CS_CLOSED) && (rdata_r.lport == dport_r) &&
                           (rdata_r.rport == sport_r);
  assign stat.sock_ok    = sock_ok;

  always_comb begin
    mem_we = 1'b0;
    wrec   = rdata_r;
    cs_we  = 1'b0;
    cs_new = cs_cur;
    prod   = 1'b0;
    r      = '0;
    np_inc = 1'b0;
    if (cmd.apply) begin
      case (mode_r)
        MODE_CONNECT: begin
          wrec.lport     = next_port_r;
          wrec.rport     = pport_r;
          wrec.rip       = pip_r;
          wrec.seq       = isn_base_r + (32'(addr) << 16);
          wrec.ack       = '0;
          wrec.retry_cnt = '0;
          wrec.wait_cnt  = '0;
          mem_we         = 1'b1;
          cs_we          = 1'b1;
          cs_new         = CS_SYN;
          np_inc         = 1'b1;
          prod           = 1'b1;
          r              = mk_seg(slot4, CS_SYN, wrec, wrec.seq, 32'd0, FLG_SYN);
        end
        MODE_SEGMENT: begin
          prod = 1'b1;
          if ((flags_r & FLG_RST) != 8'd0) begin
            cs_we  = 1'b1;
            cs_new = CS_CLOSED;
            r      = mk_plain(slot4, CS_CLOSED, STS_DONE);
          end else if (cs_cur == CS_SYN && (flags_r & FLG_SYN) != 8'd0 &&
                       (flags_r & FLG_ACK) != 8'd0) begin
            wrec.ack = sseq_r + 32'd1;
            wrec.seq = sack_r;
            mem_we   = 1'b1;
            cs_we    = 1'b1;
            cs_new   = CS_EST;
            r        = mk_seg(slot4, CS_EST, wrec, wrec.seq, wrec.ack, FLG_ACK);
          end else if (cs_cur == CS_EST && dlen_r != 16'd0) begin
            wrec.ack = sseq_r + 32'(dlen_r);
            mem_we   = 1'b1;
            r        = mk_seg(slot4, CS_EST, wrec, wrec.seq, wrec.ack, FLG_ACK);
          end else if (cs_cur == CS_EST && (flags_r & FLG_FIN) != 8'd0) begin
            wrec.ack = sseq_r + 32'd1;
            mem_we   = 1'b1;
            cs_we    = 1'b1;
            cs_new   = CS_CLOSED;
            r        = mk_seg(slot4, CS_CLOSED, wrec, wrec.seq, wrec.ack, FLG_FINACK);
          end else begin
            r = mk_plain(slot4, cs_cur, STS_IGNORED);
          end
        end
        MODE_SEND: begin
          prod = 1'b1;
          if (cs_cur != CS_EST) begin
            r = mk_plain(sock_r, cs_cur, STS_IGNORED);
          end else begin
            r        = mk_seg(slot4, CS_EST, rdata_r, rdata_r.seq, rdata_r.ack, FLG_PSHACK);
            wrec.seq = rdata_r.seq + 32'(dlen_r);
            mem_we   = 1'b1;
          end
        end
        MODE_TICK: begin
          mem_we = 1'b1;
          if (rdata_r.wait_cnt < retry_int_r) begin
            wrec.wait_cnt = rdata_r.wait_cnt + 8'd1;
          end else begin
            wrec.wait_cnt = '0;
            if (rdata_r.retry_cnt >= retry_lim_r) begin
              cs_we  = 1'b1;
              cs_new = CS_CLOSED;
            end else begin
              wrec.retry_cnt = rdata_r.retry_cnt + 8'd1;
              prod           = (cnt_r < CNT_W'(MAX_RESULTS));
              r              = mk_seg(slot4, CS_SYN, rdata_r, rdata_r.seq, 32'd0, FLG_SYN);
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.plain) begin
      prod = 1'b1;
      case (mode_r)
        MODE_CONNECT: r = mk_plain(4'd0, CS_CLOSED, STS_NOFREE);
        MODE_SEND:    r = mk_plain(sock_r, CS_CLOSED, STS_IGNORED);
        MODE_QUERY: begin
          if (sock_ok) r = mk_plain(sock_r, cs_r[sock_ix], STS_DONE);
          else         r = mk_plain(sock_r, CS_CLOSED, STS_IGNORED);
        end
        default:      r = mk_plain(4'd0, CS_CLOSED, STS_IGNORED);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_port_r <= FIRST_PORT_RST;
      retry_int_r  <= RETRY_INT_RST;
      retry_lim_r  <= RETRY_LIM_RST;
      isn_base_r   <= ISN_BASE_RST;
      next_port_r  <= FIRST_PORT_RST;
    end else begin
      if (np_inc) next_port_r <= next_port_r + 16'd1;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_FIRST_PORT: begin
            first_port_r <= pwdata[15:0];
            next_port_r  <= pwdata[15:0];
          end
          REG_RETRY_INT: retry_int_r <= pwdata[7:0];
          REG_RETRY_LIM: retry_lim_r <= pwdata[7:0];
          REG_ISN_BASE:  isn_base_r  <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      sock_r  <= in_sock_index;
      pip_r   <= in_peer_ip;
      pport_r <= in_peer_port;
      sport_r <= in_seg_src_port;
      dport_r <= in_seg_dst_port;
      sseq_r  <= in_seg_seq;
      sack_r  <= in_seg_ack;
      flags_r <= in_seg_flags;
      dlen_r  <= in_data_len;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= wrec;
    if (cmd.rd) rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) cs_r[i] <= CS_CLOSED;
    end else if (cs_we) begin
      cs_r[addr] <= cs_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      if (cmd.flush) begin
        out_res_r   <= pend_v_r ? pend_r : res_t'(0);
        out_valid_r <= 1'b1;
        out_last_r  <= 1'b1;
        pend_v_r    <= 1'b0;
        cnt_r       <= '0;
      end else if (prod) begin
        pend_r   <= r;
        pend_v_r <= 1'b1;
        cnt_r    <= cnt_r + 1'b1;
        if (pend_v_r) begin
          out_res_r   <= pend_r;
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

/* sv/tcp_connection_engine.sv */
// tcp_connection_engine: top level joining the sequencer and the datapath
// depends on tce_pkg, tce_ctrl and tce_dp
//
//   channel   handshake                         payload
//   config    psel/penable/pwrite, pready=1     paddr, pwdata, prdata
//   request   start & !busy                     in_*
//   result    out_valid, one cycle              out_*, out_last
//
// connect, segment and tick walk the slots one per cycle, with S_EVAL added for
// a slot read from the table memory; send steps through S_SCAN, S_EVAL, S_FLUSH,
// query through S_SCAN, S_FLUSH; a result waits in a holding register until
// the next result of the request or the final flush
// reset closes every slot and restores the registers; no clearing pass
// the result side cannot stall; busy falls as the last result appears
module tcp_connection_engine import tce_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_mode,
  input  logic [3:0]        in_sock_index,
  input  logic [31:0]       in_peer_ip,
  input  logic [15:0]       in_peer_port,
  input  logic [15:0]       in_seg_src_port,
  input  logic [15:0]       in_seg_dst_port,
  input  logic [31:0]       in_seg_seq,
  input  logic [31:0]       in_seg_ack,
  input  logic [7:0]        in_seg_flags,
  input  logic [15:0]       in_data_len,
  output logic              out_valid,
  output logic              out_has_segment,
  output logic [3:0]        out_slot,
  output logic [1:0]        out_slot_state,
  output logic [1:0]        out_status,
  output logic [15:0]       out_tx_sport,
  output logic [15:0]       out_tx_dport,
  output logic [31:0]       out_tx_dip,
  output logic [31:0]       out_seq_out,
  output logic [31:0]       out_ack_out,
  output logic [7:0]        out_flags_out,
  output logic              out_last
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  ctrl_cmd_t     cmd;
  dp_stat_t      stat;
  logic [SW-1:0] idx;
  res_t          res;

  tce_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd),
    .idx   (idx)
  );

  tce_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_mode         (in_mode),
    .in_sock_index   (in_sock_index),
    .in_peer_ip      (in_peer_ip),
    .in_peer_port    (in_peer_port),
    .in_seg_src_port (in_seg_src_port),
    .in_seg_dst_port (in_seg_dst_port),
    .in_seg_seq      (in_seg_seq),
    .in_seg_ack      (in_seg_ack),
    .in_seg_flags    (in_seg_flags),
    .in_data_len     (in_data_len),
    .cmd             (cmd),
    .idx             (idx),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_res         (res),
    .out_last        (out_last)
  );

  assign out_has_segment = res.has_segment;
  assign out_slot        = res.slot;
  assign out_slot_state  = res.slot_state;
  assign out_status      = res.status;
  assign out_tx_sport    = res.tx_sport;
  assign out_tx_dport    = res.tx_dport;
  assign out_tx_dip      = res.tx_dip;
  assign out_seq_out     = res.seq_out;
  assign out_ack_out     = res.ack_out;
  assign out_flags_out   = res.flags_out;

endmodule

/* sv/tce_check.sv */
// tce_sva: port-level checks on the tcp connection engine
// depends on tce_pkg; bound to tcp_connection_engine
module tce_sva import tce_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_has_segment,
  input logic [1:0]  out_status,
  input logic [31:0] out_seq_out,
  input logic [7:0]  out_flags_out,
  input logic        out_last
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_out_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result issued without a request in work");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result right after the last one");

  a_no_seg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_segment) |-> (out_flags_out == 8'd0 && out_seq_out == 32'd0))
    else $error("segment fields set on a result without segment");

  a_nofree: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STS_NOFREE) |-> (out_last && !out_has_segment))
    else $error("no-free result malformed");

endmodule

bind tcp_connection_engine tce_sva u_tce_sva (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_has_segment (out_has_segment),
  .out_status      (out_status),
  .out_seq_out     (out_seq_out),
  .out_flags_out   (out_flags_out),
  .out_last        (out_last)
);

/* bench/tce_check.sv */
// tce_check: watches the config, request and result channels of the tcp connection engine,
// keeps its own copy of the connection table and compares every result in order
// depends on tce_pkg
`timescale 1ns / 100ps
module tce_check import tce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              start,
  input  logic              busy,
  input  logic [2:0]        in_mode,
  input  logic [3:0]        in_sock_index,
  input  logic [31:0]       in_peer_ip,
  input  logic [15:0]       in_peer_port,
  input  logic [15:0]       in_seg_src_port,
  input  logic [15:0]       in_seg_dst_port,
  input  logic [31:0]       in_seg_seq,
  input  logic [31:0]       in_seg_ack,
  input  logic [7:0]        in_seg_flags,
  input  logic [15:0]       in_data_len,
  input  logic              out_valid,
  input  logic              out_has_segment,
  input  logic [3:0]        out_slot,
  input  logic [1:0]        out_slot_state,
  input  logic [1:0]        out_status,
  input  logic [15:0]       out_tx_sport,
  input  logic [15:0]       out_tx_dport,
  input  logic [31:0]       out_tx_dip,
  input  logic [31:0]       out_seq_out,
  input  logic [31:0]       out_ack_out,
  input  logic [7:0]        out_flags_out,
  input  logic              out_last,
  output int                fails,
  output int                pending
);

  localparam int NS = NUM_SLOTS_DEF;

  typedef struct {
    res_t r;
    logic last;
  } seg_exp_t;

  seg_exp_t   seg_q[$];

  conn_st_t    cst [NS];
  logic [15:0] lport [NS];
  logic [15:0] rport [NS];
  logic [31:0] rip [NS];
  logic [31:0] seqn [NS];
  logic [31:0] ackn [NS];
  logic [7:0]  retries [NS];
  logic [7:0]  waited [NS];
  logic [15:0] next_port;
  logic [7:0]  retry_int;
  logic [7:0]  retry_lim;
  logic [31:0] isn_base;

  function automatic res_t plain_res(logic [3:0] s, logic [1:0] st, logic [1:0] sts);
    res_t r;
    r = '0;
    r.slot = s;
    r.slot_state = st;
    r.status = sts;
    return r;
  endfunction

  function automatic res_t seg_res(int s, logic [31:0] sq, logic [31:0] ak, logic [7:0] fl);
    res_t r;
    r = plain_res(s[3:0], cst[s], STS_DONE);
    r.has_segment = 1'b1;
    r.tx_sport = lport[s];
    r.tx_dport = rport[s];
    r.tx_dip = rip[s];
    r.seq_out = sq;
    r.ack_out = ak;
    r.flags_out = fl;
    return r;
  endfunction

  task automatic reset_table();
    for (int i = 0; i < NS; i++) begin
      cst[i] = CS_CLOSED;
      lport[i] = '0;
      rport[i] = '0;
      rip[i] = '0;
      seqn[i] = '0;
      ackn[i] = '0;
      retries[i] = '0;
      waited[i] = '0;
    end
    retry_int = RETRY_INT_RST;
    retry_lim = RETRY_LIM_RST;
    isn_base = ISN_BASE_RST;
    next_port = FIRST_PORT_RST;
    seg_q.delete();
  endtask

  task automatic predict_request();
    res_t res[$];
    int   hit;
    int   si;
    seg_exp_t e;
    hit = -1;
    si = in_sock_index;
    case (in_mode)
      MODE_CONNECT: begin
        for (int i = 0; i < NS; i++)
          if (hit < 0 && cst[i] == CS_CLOSED) hit = i;
        if (hit < 0) begin
          res.push_back(plain_res('0, CS_CLOSED, STS_NOFREE));
        end else begin
          lport[hit] = next_port;
          next_port = next_port + 16'd1;
          rport[hit] = in_peer_port;
          rip[hit] = in_peer_ip;
          seqn[hit] = isn_base + (hit << 16);
          ackn[hit] = '0;
          cst[hit] = CS_SYN;
          retries[hit] = '0;
          waited[hit] = '0;
          res.push_back(seg_res(hit, seqn[hit], '0, FLG_SYN));
        end
      end
      MODE_SEGMENT: begin
        for (int i = 0; i < NS; i++)
          if (hit < 0 && cst[i] != CS_CLOSED && lport[i] == in_seg_dst_port &&
              rport[i] == in_seg_src_port) hit = i;
        if (hit < 0) begin
          res.push_back(plain_res('0, CS_CLOSED, STS_IGNORED));
        end else if ((in_seg_flags & FLG_RST) != 0) begin
          cst[hit] = CS_CLOSED;
          res.push_back(plain_res(hit[3:0], CS_CLOSED, STS_DONE));
        end else if (cst[hit] == CS_SYN && (in_seg_flags & FLG_SYN) != 0 &&
                     (in_seg_flags & FLG_ACK) != 0) begin
          ackn[hit] = in_seg_seq + 32'd1;
          seqn[hit] = in_seg_ack;
          cst[hit] = CS_EST;
          res.push_back(seg_res(hit, seqn[hit], ackn[hit], FLG_ACK));
        end else if (cst[hit] == CS_EST && in_data_len != 0) begin
          ackn[hit] = in_seg_seq + in_data_len;
          res.push_back(seg_res(hit, seqn[hit], ackn[hit], FLG_ACK));
        end else if (cst[hit] == CS_EST && (in_seg_flags & FLG_FIN) != 0) begin
          ackn[hit] = in_seg_seq + 32'd1;
          cst[hit] = CS_CLOSED;
          res.push_back(seg_res(hit, seqn[hit], ackn[hit], FLG_FINACK));
        end else begin
          res.push_back(plain_res(hit[3:0], cst[hit], STS_IGNORED));
        end
      end
      MODE_SEND: begin
        if (si >= NS) begin
          res.push_back(plain_res(in_sock_index, CS_CLOSED, STS_IGNORED));
        end else if (cst[si] != CS_EST) begin
          res.push_back(plain_res(in_sock_index, cst[si], STS_IGNORED));
        end else begin
          res.push_back(seg_res(si, seqn[si], ackn[si], FLG_PSHACK));
          seqn[si] = seqn[si] + in_data_len;
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < NS; i++) begin
          if (cst[i] != CS_SYN) continue;
          if (waited[i] < retry_int) begin
            waited[i] = waited[i] + 8'd1;
            continue;
          end
          waited[i] = '0;
          if (retries[i] >= retry_lim) begin
            cst[i] = CS_CLOSED;
          end else begin
            retries[i] = retries[i] + 8'd1;
            if (res.size() < MAX_RESULTS) res.push_back(seg_res(i, seqn[i], '0, FLG_SYN));
          end
        end
        if (res.size() == 0) res.push_back(plain_res('0, CS_CLOSED, STS_DONE));
      end
      MODE_QUERY: begin
        if (si >= NS) res.push_back(plain_res(in_sock_index, CS_CLOSED, STS_IGNORED));
        else res.push_back(plain_res(in_sock_index, cst[si], STS_DONE));
      end
      default: res.push_back(plain_res('0, CS_CLOSED, STS_IGNORED));
    endcase
    foreach (res[k]) begin
      e.r = res[k];
      e.last = (k == res.size() - 1);
      seg_q.push_back(e);
    end
  endtask

  task automatic check_field(string nm, logic [31:0] want, logic [31:0] got, inout logic bad);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", nm, want, got);
      bad = 1'b1;
    end
  endtask

  task automatic check_result();
    seg_exp_t e;
    logic     bad;
    bad = 1'b0;
    if (seg_q.size() == 0) begin
      $error("result with no request outstanding: slot %0d status %0d", out_slot, out_status);
      fails++;
    end else begin
      e = seg_q.pop_front();
      check_field("has_segment", e.r.has_segment, out_has_segment, bad);
      check_field("slot", e.r.slot, out_slot, bad);
      check_field("slot_state", e.r.slot_state, out_slot_state, bad);
      check_field("status", e.r.status, out_status, bad);
      check_field("tx_sport", e.r.tx_sport, out_tx_sport, bad);
      check_field("tx_dport", e.r.tx_dport, out_tx_dport, bad);
      check_field("tx_dip", e.r.tx_dip, out_tx_dip, bad);
      check_field("seq_out", e.r.seq_out, out_seq_out, bad);
      check_field("ack_out", e.r.ack_out, out_ack_out, bad);
      check_field("flags_out", e.r.flags_out, out_flags_out, bad);
      check_field("last", e.last, out_last, bad);
      if (bad) fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_table();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FIRST_PORT: next_port = pwdata[15:0];
          REG_RETRY_INT: retry_int = pwdata[7:0];
          REG_RETRY_LIM: retry_lim = pwdata[7:0];
          REG_ISN_BASE:  isn_base = pwdata;
          default: ;
        endcase
      end
      if (out_valid) check_result();
      if (start && !busy) predict_request();
    end
    pending = seg_q.size();
  end

endmodule

/* bench/tb_top.sv */
// tb_top: stimulus and verdict for the tcp connection engine
// drives requests and register writes; tce_check predicts and compares; depends on tce_pkg
`timescale 1ns / 100ps
module tb_top;
  import tce_pkg::*;

  typedef struct {
    logic [2:0]  mode;
    logic [3:0]  sidx;
    logic [31:0] ip;
    logic [15:0] pport;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [15:0] dlen;
  } req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  req_t rq = '{default: '0};
  logic out_valid, out_has_segment, out_last;
  logic [3:0] out_slot;
  logic [1:0] out_slot_state, out_status;
  logic [15:0] out_tx_sport, out_tx_dport;
  logic [31:0] out_tx_dip, out_seq_out, out_ack_out;
  logic [7:0] out_flags_out;
  int fails, pending;
  int items = 0;
  logic idle_on = 1'b1;
  res_t got;
  logic [15:0] port_pool [4] = '{16'd0, 16'd80, 16'd443, 16'd65535};
  logic [15:0] open_lp [$];
  logic [15:0] open_rp [$];
  logic [3:0]  open_slot [$];

  always #5 clk = ~clk;

  tcp_connection_engine dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy,
    .in_mode(rq.mode), .in_sock_index(rq.sidx), .in_peer_ip(rq.ip), .in_peer_port(rq.pport),
    .in_seg_src_port(rq.sport), .in_seg_dst_port(rq.dport), .in_seg_seq(rq.seq),
    .in_seg_ack(rq.ack), .in_seg_flags(rq.flags), .in_data_len(rq.dlen),
    .out_valid, .out_has_segment, .out_slot, .out_slot_state, .out_status,
    .out_tx_sport, .out_tx_dport, .out_tx_dip, .out_seq_out, .out_ack_out,
    .out_flags_out, .out_last
  );

  tce_check chk (
    .clk, .rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .start, .busy,
    .in_mode(rq.mode), .in_sock_index(rq.sidx), .in_peer_ip(rq.ip), .in_peer_port(rq.pport),
    .in_seg_src_port(rq.sport), .in_seg_dst_port(rq.dport), .in_seg_seq(rq.seq),
    .in_seg_ack(rq.ack), .in_seg_flags(rq.flags), .in_data_len(rq.dlen),
    .out_valid, .out_has_segment, .out_slot, .out_slot_state, .out_status,
    .out_tx_sport, .out_tx_dport, .out_tx_dip, .out_seq_out, .out_ack_out,
    .out_flags_out, .out_last, .fails, .pending
  );

  function automatic req_t rand_req();
    req_t r;
    r.mode = $urandom_range(0, 7);
    r.sidx = $urandom;
    r.ip = $urandom;
    r.pport = $urandom;
    r.sport = $urandom;
    r.dport = $urandom;
    r.seq = $urandom;
    r.ack = $urandom;
    r.flags = $urandom;
    r.dlen = $urandom;
    return r;
  endfunction

  function automatic logic [15:0] rand_len();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1500));
  endfunction

  // issue one request; with grab set, start drops after accept and the first result is kept
  task automatic issue(req_t r, logic grab);
    rq = r;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    items++;
    @(negedge clk);
    if (grab) begin
      start = 1'b0;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
      got = '{out_has_segment, out_slot, out_slot_state, out_status, out_tx_sport,
              out_tx_dport, out_tx_dip, out_seq_out, out_ack_out, out_flags_out};
      @(negedge clk);
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  task automatic req_mode(logic [2:0] m, logic [3:0] s);
    req_t r;
    r = rand_req();
    r.mode = m;
    r.sidx = s;
    issue(r, 1'b0);
  endtask

  task automatic segment(logic [15:0] sp, logic [15:0] dp, logic [7:0] fl, logic [15:0] len);
    req_t r;
    r = rand_req();
    r.mode = MODE_SEGMENT;
    r.sport = sp;
    r.dport = dp;
    r.flags = fl;
    r.dlen = len;
    issue(r, 1'b1);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic forget_open();
    open_lp.delete();
    open_rp.delete();
    open_slot.delete();
  endtask

  // connect, optional ticks, then the syn+ack; an established slot joins the open list
  task automatic open_conn(int ticks);
    req_t r;
    logic [15:0] lp, rp;
    logic [3:0] s;
    r = rand_req();
    r.mode = MODE_CONNECT;
    r.pport = port_pool[$urandom_range(0, 3)];
    issue(r, 1'b1);
    if (got.status != STS_DONE) return;
    lp = got.tx_sport;
    rp = got.tx_dport;
    s = got.slot;
    repeat (ticks) req_mode(MODE_TICK, '0);
    segment(rp, lp, FLG_SYN | FLG_ACK | (8'($urandom) & ~FLG_RST), '0);
    if (got.slot_state == CS_EST) begin
      open_lp.push_back(lp);
      open_rp.push_back(rp);
      open_slot.push_back(s);
    end
  endtask

  task automatic work_open();
    int k;
    req_t r;
    k = $urandom_range(0, open_lp.size() - 1);
    case ($urandom_range(0, 5))
      0, 1: begin
        r = rand_req();
        r.mode = MODE_SEND;
        r.sidx = open_slot[k];
        r.dlen = rand_len();
        issue(r, 1'b0);
      end
      2, 3: segment(open_rp[k], open_lp[k], 8'($urandom) & ~FLG_RST, rand_len());
      4: begin
        segment(open_rp[k], open_lp[k], (8'($urandom) | FLG_FIN) & ~FLG_RST, '0);
        open_lp.delete(k);
        open_rp.delete(k);
        open_slot.delete(k);
      end
      default: begin
        segment(open_rp[k], open_lp[k], 8'($urandom) | FLG_RST, 16'($urandom));
        open_lp.delete(k);
        open_rp.delete(k);
        open_slot.delete(k);
      end
    endcase
  endtask

  task automatic random_phase(int stop_at);
    req_t r;
    while (items < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: if (open_lp.size() < 12) open_conn($urandom_range(0, 3));
        3, 4, 5: if (open_lp.size() != 0) work_open();
        6: req_mode(MODE_TICK, '0);
        7: req_mode(MODE_QUERY, 4'($urandom));
        default: begin
          r = rand_req();
          issue(r, 1'b0);
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // idle table, unknown modes, a full connection life, a reset connection, random traffic
    req_mode(MODE_QUERY, 4'd0);
    req_mode(MODE_QUERY, 4'd15);
    req_mode(MODE_SEND, 4'd3);
    segment(16'hffff, 16'h0000, FLG_ACK, 16'd0);
    req_mode(MODE_TICK, '0);
    req_mode(3'd5, '0);
    req_mode(3'd6, '0);
    req_mode(3'd7, '0);
    open_conn(0);
    if (open_lp.size() != 0) begin
      segment(open_rp[0], open_lp[0], FLG_ACK, 16'd0);
      req_mode(MODE_SEND, open_slot[0]);
      segment(open_rp[0], open_lp[0], FLG_ACK, 16'hffff);
      segment(open_rp[0], open_lp[0], FLG_SYN | FLG_ACK, 16'd0);
      segment(open_rp[0], open_lp[0], FLG_FIN | FLG_ACK, 16'd0);
    end
    forget_open();
    open_conn(2);
    if (open_lp.size() != 0) segment(open_rp[0], open_lp[0], FLG_RST, 16'd0);
    forget_open();
    random_phase(90);
    drain();

    // short retry timer: fill the table, overflow, mass retransmit, then silent close
    write_reg(REG_FIRST_PORT, 32'd65534);
    write_reg(REG_RETRY_INT, 32'd1);
    write_reg(REG_RETRY_LIM, 32'd1);
    write_reg(REG_ISN_BASE, 32'hffff_ffff);
    forget_open();
    for (int i = 0; i < 12; i++) req_mode(MODE_TICK, '0);
    for (int i = 0; i < 17; i++) req_mode(MODE_CONNECT, '0);
    for (int i = 0; i < 5; i++) req_mode(MODE_TICK, '0);
    random_phase(190);
    drain();

    write_reg(REG_FIRST_PORT, 32'd0);
    write_reg(REG_RETRY_INT, 32'd255);
    write_reg(REG_RETRY_LIM, 32'd255);
    write_reg(REG_ISN_BASE, 32'd0);
    forget_open();
    random_phase(260);
    drain();

    write_reg(REG_FIRST_PORT, $urandom);
    write_reg(REG_RETRY_INT, $urandom_range(1, 6));
    write_reg(REG_RETRY_LIM, $urandom_range(0, 3));
    write_reg(REG_ISN_BASE, $urandom);
    forget_open();
    idle_on = 1'b0;
    random_phase(320);

    drain();
    if (fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
sv/tce_pkg.sv
sv/tce_ctrl.sv
sv/tce_dp.sv
sv/tcp_connection_engine.sv
sv/tce_check.sv
bench/tce_check.sv
bench/tb_top.sv
